@@ src/mbp_pkg.sv @@
// Shared types and constants of the MSB-first bit packer.
package mbp_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned LEN_W         = 6;
    localparam int unsigned JOB_BYTES     = 4;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam logic [LEN_W-1:0] MAX_FIELD_LEN = 6'd32;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic               func;
        logic [VALUE_W-1:0] field_value;
        logic [LEN_W-1:0]   field_length;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_out_word;

    // Bytes completed by one input word, first byte in the top lane.
    typedef struct packed {
        logic [JOB_BYTES*BYTE_W-1:0] bytes;
        logic [2:0]                  count;
    } t_job;

endpackage

@@ src/mbp_front.sv @@
// Front end: accepts input words, merges them with the held bits, builds byte jobs.
module mbp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mbp_pkg::t_in_word i_word,
    input  logic            i_queue_full,
    output logic            o_ready,
    output logic            o_push,
    output mbp_pkg::t_job   o_job
);
    import mbp_pkg::*;

    logic [BYTE_W-1:0]  r_held;
    logic [2:0]         r_cnt;
    logic [BYTE_W-1:0]  n_held;
    logic [2:0]         n_cnt;

    logic               accept;
    logic [LEN_W-1:0]   len_sat;
    logic [VALUE_W-1:0] v_left;
    logic [39:0]        merged;
    logic [LEN_W-1:0]   total;
    logic [2:0]         nbytes;
    logic [BYTE_W-1:0]  rem_byte;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        len_sat = (i_word.field_length > MAX_FIELD_LEN) ? MAX_FIELD_LEN : i_word.field_length;
        // Left-aligning the value drops every bit above the field length.
        v_left  = i_word.field_value << (MAX_FIELD_LEN - len_sat);
        merged  = {r_held, 32'd0} | ({v_left, 8'd0} >> r_cnt);
        total   = LEN_W'(r_cnt) + len_sat;
        nbytes  = total[5:3];
        case (nbytes)
            3'd0:    rem_byte = merged[39:32];
            3'd1:    rem_byte = merged[31:24];
            3'd2:    rem_byte = merged[23:16];
            3'd3:    rem_byte = merged[15:8];
            default: rem_byte = merged[7:0];
        endcase
    end

    always_comb begin
        if (i_word.func == FUNC_FLUSH) begin
            o_job.bytes = {r_held, 24'd0};
            o_job.count = (r_cnt != 3'd0) ? 3'd1 : 3'd0;
            n_held      = '0;
            n_cnt       = '0;
        end else begin
            o_job.bytes = merged[39:8];
            o_job.count = nbytes;
            n_held      = rem_byte;
            n_cnt       = total[2:0];
        end
        o_push = accept && (o_job.count != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_cnt  <= '0;
        end else if (accept) begin
            r_held <= n_held;
            r_cnt  <= n_cnt;
        end
    end

endmodule

@@ src/mbp_queue.sv @@
// Short job queue between the front end and the byte emitter.
module mbp_queue #(
    parameter int unsigned DEPTH = mbp_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mbp_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output mbp_pkg::t_job o_head
);
    import mbp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

@@ src/mbp_back.sv @@
// Back end: walks the head job a byte per cycle into r_word unless stalled.
module mbp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  mbp_pkg::t_job     i_head,
    input  logic              i_ready,
    output logic              o_pop,
    output logic              o_valid,
    output mbp_pkg::t_out_word o_word
);
    import mbp_pkg::*;

    logic              r_valid;
    t_out_word         r_word;
    logic [1:0]        r_idx;
    logic [1:0]        n_idx;
    logic              load;
    logic              is_last;
    logic [BYTE_W-1:0] sel_byte;

    assign load    = !i_empty && (!r_valid || i_ready);
    assign is_last = ((3'(r_idx) + 3'd1) == i_head.count);
    assign o_pop   = load && is_last;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.bytes[31:24];
            2'd1:    sel_byte = i_head.bytes[23:16];
            2'd2:    sel_byte = i_head.bytes[15:8];
            default: sel_byte = i_head.bytes[7:0];
        endcase
        if (load) begin
            n_idx = is_last ? 2'd0 : r_idx + 2'd1;
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word.out_byte <= sel_byte;
            r_word.last     <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

@@ src/msb_first_bit_packer.sv @@
// Top level of the MSB-first bit packer: front end, job queue and byte emitter.
// Usage: each input word is either a write of 0 to 32 bits (func = write) or a flush
// (func = flush). Write bits are appended most significant first after the up to
// seven held bits; each completed byte leaves on the output channel as one word,
// earliest bits in bit 7, with last set on the final byte of the input word.
// A flush pads the held bits with zeros and sends one byte if any bits were held.
// Words that complete no byte produce no output at all.
// Both channels use valid/ready; a word moves when valid and ready are high together.
// An accepted word's job is written into the job queue, and its first byte is then
// loaded from there into the output register once that is free, raising o_valid.
// Throughput: one output byte per cycle while the receiver is ready, and a write
// completes up to four bytes. The byte emitter sets the sustained rate;
// the front end takes a new word every cycle while the job queue has room.
// Reset (synchronous, active low) clears the held bits, empties the queue and drops
// any output word not yet taken.
// When the receiver stalls, the output register holds its word, the queue fills, and
// then o_ready falls until the emitter drains a job.
module msb_first_bit_packer #(
    parameter int unsigned QUEUE_DEPTH = mbp_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mbp_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output mbp_pkg::t_out_word o_word
);
    import mbp_pkg::*;

    // Job handoff between the front end and the queue.
    logic push;
    t_job front_job;

    // Queue head and status seen by the emitter.
    logic queue_full;
    logic queue_empty;
    logic pop;
    t_job head_job;

    mbp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_word       (i_word),
        .i_queue_full (queue_full),
        .o_ready      (o_ready),
        .o_push       (push),
        .o_job        (front_job)
    );

    mbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_head  (head_job)
    );

    // The emitter pops a job in the same cycle that it loads the job's final byte.
    mbp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (queue_empty),
        .i_head  (head_job),
        .i_ready (i_ready),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

`ifndef SYNTHESIS
    // The rest of a job is already queued, so a taken non-final byte is followed at once.
    a_job_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_word.last) |=> o_valid)
        else $error("output gap inside one input word");

    // The emitter never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !queue_empty)
        else $error("queue popped while empty");

    // A job is never pushed into a full queue unless one leaves in the same cycle.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!queue_full || pop))
        else $error("queue pushed while full");
`endif

endmodule
